### sv/cmrls_pkg.sv
// Shared types and constants for the cable motor rest-length step block.
`default_nettype none

package cmrls_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int CFG_BITS     = 31;
  localparam int LEN_BITS     = 31;
  localparam int CFG_IDX_BITS = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [CFG_BITS-1:0]         cfg_word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t ONE_Q    = word_t'(1) <<< FRAC_BITS;

  typedef struct packed {
    word_t desired_torque;
    word_t cable_tension;
    word_t time_step;
  } in_t;

  typedef struct packed {
    logic [LEN_BITS-1:0] rest_length;
    word_t               applied_torque;
    word_t               motor_speed;
    logic                step_error;
  } out_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SPOOL_RADIUS      = 3'd0,
    REG_MOTOR_FRICTION    = 3'd1,
    REG_INVERSE_INERTIA   = 3'd2,
    REG_MAX_TENSION       = 3'd3,
    REG_SPEED_DROOP       = 3'd4,
    REG_BACKDRIVABLE      = 3'd5,
    REG_MIN_REST_LENGTH   = 3'd6,
    REG_START_REST_LENGTH = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_MUL,
    FSM_POST,
    FSM_DONE
  } fsm_e;

  // One entry per use of the shared multiplier, in issue order.
  typedef enum logic [3:0] {
    ST_DROOP,
    ST_STALL_TRQ,
    ST_LIMIT,
    ST_FRICTION,
    ST_TENSION,
    ST_INERTIA,
    ST_VELOCITY,
    ST_SPOOL,
    ST_LENGTH
  } step_e;

endpackage

`default_nettype wire

### sv/cable_motor_rest_length_step_top.sv
// Cable motor rest-length integrator: one shared Q16.16 multiplier under a step sequencer.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one beat per tick: desired torque,
// cable tension and time step. Output channel (out_valid_o / out_stall_i / out_data_o) returns
// one beat per input beat: rest length, applied torque, motor speed and an error flag.
// The user must write registers through cfg_we_i / cfg_index_i / cfg_wdata_i only while the
// block is idle; the block itself does not enforce this. Writing the start rest length also
// reloads the rest-length state. An item runs nine multiplies on the one 32x32 multiplier,
// each as a multiply state then an add/saturate state, and the block takes no new beat
// until the result is loaded into the output register. A non-positive time step skips the
// arithmetic: state held, step_error set and applied torque reported as zero.
// in_stall_o is high from the accepted beat until its result has entered the output register.
// If the receiver stalls while an earlier result still waits, the finished item holds in its
// last state until the output register frees up; the output beat holds steady while stalled.
// Reset (rst_ni low) empties the output register, loads register defaults, clears the
// velocity and sets the rest length to the default start rest length.
`default_nettype none

module cable_motor_rest_length_step_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire cmrls_pkg::in_t                  in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output cmrls_pkg::out_t                      out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [cmrls_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  wire logic [cmrls_pkg::CFG_BITS-1:0]  cfg_wdata_i
);
  import cmrls_pkg::*;

  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int RES_BITS  = PROD_BITS - FRAC_BITS;

  // (a*b) >> FRAC_BITS toward zero, saturated to the word range
  function automatic word_t mul_q(input word_t a, input word_t b);
    logic                  neg;
    logic [WORD_BITS-1:0]  ua;
    logic [WORD_BITS-1:0]  ub;
    logic [PROD_BITS-1:0]  p;
    logic [RES_BITS-1:0]   r;
    logic [RES_BITS-1:0]   cap;
    logic [WORD_BITS-1:0]  rw;
    neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    ua  = a[WORD_BITS-1] ? (~a + 1'b1) : a;
    ub  = b[WORD_BITS-1] ? (~b + 1'b1) : b;
    p   = PROD_BITS'(ua) * PROD_BITS'(ub);
    r   = p[PROD_BITS-1:FRAC_BITS];
    cap = RES_BITS'(WORD_MAX) + RES_BITS'(neg);
    if (r > cap) r = cap;
    rw  = r[WORD_BITS-1:0];
    return neg ? word_t'(~rw + 1'b1) : word_t'(rw);
  endfunction

  function automatic word_t sat_sum(input logic signed [WORD_BITS:0] x);
    if (x[WORD_BITS] != x[WORD_BITS-1]) begin
      return x[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return x[WORD_BITS-1:0];
  endfunction

  function automatic word_t cfg_word(input cfg_word_t c);
    return word_t'({{(WORD_BITS-CFG_BITS){1'b0}}, c});
  endfunction

  // registers
  cfg_word_t radius_q, friction_q, inertia_q, max_tension_q, droop_q, min_len_q;
  logic      bd_q;

  fsm_e  state_q, state_d;
  step_e step_q;
  in_t   in_q;
  logic  err_q;
  word_t prod_q, factor_q, tmp_q, acc_q, applied_q, vel_q, len_q;
  out_t  out_q;
  logic  out_valid_q, out_valid_d;

  logic  in_acc, dt_bad, slot_free, load_out, mul_en, post_en, last_step;
  word_t op_a, op_b, absv, limit, len_sum, min_w, vt;
  logic signed [WORD_BITS:0] absd, factor_raw;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign dt_bad    = in_data_i.time_step[WORD_BITS-1] || (in_data_i.time_step == '0);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign last_step = (step_q == ST_LENGTH);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: if (in_valid_i) state_d = dt_bad ? FSM_DONE : FSM_MUL;
      FSM_MUL:  state_d = FSM_POST;
      FSM_POST: state_d = last_step ? FSM_DONE : FSM_MUL;
      FSM_DONE: if (slot_free) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    mul_en     = 1'b0;
    post_en    = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      FSM_IDLE: in_stall_o = 1'b0;
      FSM_MUL:  mul_en = 1'b1;
      FSM_POST: post_en = 1'b1;
      FSM_DONE: load_out = slot_free;
      default:  in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      step_q  <= ST_DROOP;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        step_q <= ST_DROOP;
      end else if (post_en && !last_step) begin
        step_q <= step_e'(step_q + 4'd1);
      end
    end
  end

  // multiplier operand select
  assign absv = (vel_q == WORD_MIN) ? WORD_MAX :
                (vel_q[WORD_BITS-1] ? word_t'(-vel_q) : vel_q);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_q)
      ST_DROOP:     begin op_a = cfg_word(droop_q);       op_b = absv;                  end
      ST_STALL_TRQ: begin op_a = cfg_word(max_tension_q); op_b = cfg_word(radius_q);    end
      ST_LIMIT:     begin op_a = tmp_q;                   op_b = factor_q;              end
      ST_FRICTION:  begin op_a = cfg_word(friction_q);    op_b = vel_q;                 end
      ST_TENSION:   begin op_a = in_q.cable_tension;      op_b = cfg_word(radius_q);    end
      ST_INERTIA:   begin op_a = acc_q;                   op_b = cfg_word(inertia_q);   end
      ST_VELOCITY:  begin op_a = acc_q;                   op_b = in_q.time_step;        end
      ST_SPOOL:     begin op_a = cfg_word(radius_q);      op_b = vel_q;                 end
      ST_LENGTH:    begin op_a = tmp_q;                   op_b = in_q.time_step;        end
      default:      begin op_a = '0;                      op_b = '0;                    end
    endcase
  end

  // post-processing helpers
  assign factor_raw = (WORD_BITS+1)'(ONE_Q) - (WORD_BITS+1)'(prod_q);
  assign limit      = prod_q;
  assign absd       = in_q.desired_torque[WORD_BITS-1] ?
                      -(WORD_BITS+1)'(in_q.desired_torque) :
                      (WORD_BITS+1)'(in_q.desired_torque);
  assign len_sum    = sat_sum((WORD_BITS+1)'(len_q) + (WORD_BITS+1)'(prod_q));
  assign min_w      = cfg_word(min_len_q);

  always_comb begin
    vt = sat_sum((WORD_BITS+1)'(vel_q) + (WORD_BITS+1)'(prod_q));
    // no backdrive: when acceleration does not push along the applied torque, forward spin is clamped to zero
    if (!bd_q && (acc_q == '0 || applied_q == '0 ||
                  (acc_q[WORD_BITS-1] != applied_q[WORD_BITS-1])) && (vt > 0)) begin
      vt = '0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q  <= in_data_i;
      err_q <= dt_bad;
    end
    if (mul_en) begin
      prod_q <= mul_q(op_a, op_b);
    end
    if (post_en) begin
      unique case (step_q)
        ST_DROOP:     factor_q <= factor_raw[WORD_BITS] ? '0 : factor_raw[WORD_BITS-1:0];
        ST_STALL_TRQ: tmp_q <= prod_q;
        ST_LIMIT: begin
          priority if (absd < (WORD_BITS+1)'(limit)) applied_q <= in_q.desired_torque;
          else if (in_q.desired_torque > 0)          applied_q <= limit;
          else if (in_q.desired_torque < 0)          applied_q <= word_t'(-limit);
          else                                       applied_q <= '0;
        end
        ST_FRICTION:  acc_q <= sat_sum((WORD_BITS+1)'(applied_q) - (WORD_BITS+1)'(prod_q));
        ST_TENSION:   acc_q <= sat_sum((WORD_BITS+1)'(acc_q) + (WORD_BITS+1)'(prod_q));
        ST_INERTIA:   acc_q <= prod_q;
        ST_VELOCITY:  ;
        ST_SPOOL:     tmp_q <= prod_q;
        ST_LENGTH:    ;
        default:      ;
      endcase
    end
    if (load_out) begin
      out_q.rest_length    <= len_q[WORD_BITS-1] ? '0 : len_q[LEN_BITS-1:0];
      out_q.applied_torque <= err_q ? '0 : applied_q;
      out_q.motor_speed    <= vel_q;
      out_q.step_error     <= err_q;
    end
  end

  // motor state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q      <= CFG_BITS'(65536);
      friction_q    <= '0;
      inertia_q     <= CFG_BITS'(65536);
      max_tension_q <= CFG_BITS'(65536);
      droop_q       <= CFG_BITS'(65536);
      bd_q          <= 1'b1;
      min_len_q     <= '0;
      vel_q         <= '0;
      len_q         <= word_t'(65536);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_SPOOL_RADIUS:      radius_q      <= cfg_wdata_i;
          REG_MOTOR_FRICTION:    friction_q    <= cfg_wdata_i;
          REG_INVERSE_INERTIA:   inertia_q     <= cfg_wdata_i;
          REG_MAX_TENSION:       max_tension_q <= cfg_wdata_i;
          REG_SPEED_DROOP:       droop_q       <= cfg_wdata_i;
          REG_BACKDRIVABLE:      bd_q          <= cfg_wdata_i[0];
          REG_MIN_REST_LENGTH:   min_len_q     <= cfg_wdata_i;
          // only reloads the rest length, below
          REG_START_REST_LENGTH: ;
          default:               ;
        endcase
      end
      if (post_en && step_q == ST_VELOCITY) begin
        vel_q <= vt;
      end
      priority if (post_en && last_step) begin
        len_q <= (len_sum < min_w) ? min_w : len_sum;
      end else if (cfg_we_i && cfg_reg_e'(cfg_index_i) == REG_START_REST_LENGTH) begin
        len_q <= cfg_word(cfg_wdata_i);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A bad time step bypasses the multiplier and goes straight to the output slot.
  a_bad_dt_skips : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && dt_bad |=> state_q == FSM_DONE && err_q)
    else $error("bad time step did not bypass the arithmetic");

  a_len_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    post_en && last_step |=> !(len_q < cfg_word(min_len_q)))
    else $error("rest length below its floor");

  a_err_torque : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.step_error |-> out_data_o.applied_torque == '0)
    else $error("error beat carries nonzero torque");

  a_no_backdrive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    post_en && step_q == ST_VELOCITY && !bd_q && applied_q == '0 |=> !(vel_q > 0))
    else $error("motor spun forward without drive torque");

  a_load_only_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire
